// File: rtl/pirl_pkg.sv
// Package for the positional insert/remove list.
// Holds operation and status codes, the per-cell command struct and shared widths.
// No dependencies.
package pirl_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned OpW         = 2;
  localparam int unsigned StatusW     = 2;

  typedef enum logic [OpW-1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Broadcast to every cell in the cycle a transfer is taken.
  typedef struct packed {
    logic ins;  // insert performed
    logic rem;  // remove performed
  } cell_cmd_t;

endpackage

// File: rtl/pirl_cell.sv
// One storage cell of the list chain: holds one item and shifts with its neighbors.
// Depends on pirl_pkg.
module pirl_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned PosW = 7
) (
  input  logic                             clk_i,
  input  pirl_pkg::cell_cmd_t              cmd_i,
  input  logic [PosW-1:0]                  pos_i,
  input  logic [pirl_pkg::ValueW-1:0]      value_i,
  input  logic [pirl_pkg::ValueW-1:0]      lower_i,
  input  logic [pirl_pkg::ValueW-1:0]      upper_i,
  output logic [pirl_pkg::ValueW-1:0]      value_o
);

  localparam logic [PosW-1:0] MyIdx = PosW'(Idx);

  logic [pirl_pkg::ValueW-1:0] value_q, value_d;
  logic                        at_pos;
  logic                        above_pos;

  assign at_pos    = (MyIdx == pos_i);
  assign above_pos = (MyIdx > pos_i);

  // On insert the cell at the position takes the new value and every cell above
  // takes its lower neighbor; on remove every cell from the position up takes
  // its upper neighbor. Cells beyond the length hold don't-care data.
  always_comb begin
    value_d = value_q;
    if (cmd_i.ins) begin
      if (at_pos) begin
        value_d = value_i;
      end else if (above_pos) begin
        value_d = lower_i;
      end
    end else if (cmd_i.rem) begin
      if (at_pos || above_pos) begin
        value_d = upper_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// File: rtl/pirl_out_buf.sv
// Two-entry output buffer (output register plus skid register) for result transfers.
// Depends on no package; width set by parameter.
module pirl_out_buf #(
  parameter int unsigned DataW = 41
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [DataW-1:0] data_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output logic [DataW-1:0] data_o,
  input  logic             out_stall_i
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  logic [DataW-1:0] out_data_q, out_data_d;
  logic [DataW-1:0] skid_data_q, skid_data_d;
  logic             in_fire, out_fire;

  // The stall comes from a register only, so it never depends on out_stall_i.
  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_data_d  = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;

endmodule

// File: rtl/positional_insert_remove_list_core.sv
// A result is registered in the output register, or in the skid register on a stall.
// Throughput: one item per cycle unless stalled; every cell shifts in the same cycle.
// Input is stalled only when both the output register and the skid register are full.
// Reset (asynchronous, active low) clears the length and the output buffer valids;
// item storage is not reset and is defined only where it has been written.
// Depends on pirl_pkg, pirl_cell and pirl_out_buf.
module positional_insert_remove_list_core #(
  parameter int unsigned CAPACITY = pirl_pkg::DefCapacity,
  parameter int unsigned CntW     = $clog2(CAPACITY + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [pirl_pkg::OpW-1:0]         operation_i,
  input  logic [CntW-1:0]                  position_i,
  input  logic signed [pirl_pkg::ValueW-1:0] value_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [pirl_pkg::ValueW-1:0] value_out_o,
  output logic [CntW-1:0]                  count_o,
  output logic [pirl_pkg::StatusW-1:0]     status_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned ResW = pirl_pkg::ValueW + CntW + pirl_pkg::StatusW;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic [CntW-1:0]                len_q, len_d;
  logic                           in_fire;
  pirl_pkg::op_e                  op;
  pirl_pkg::status_e              status;
  pirl_pkg::cell_cmd_t            cmd;
  logic [pirl_pkg::ValueW-1:0]    value_res;
  logic [pirl_pkg::ValueW-1:0]    rd_val;
  logic                           pos_lt_len, pos_le_len, full;
  logic [pirl_pkg::ValueW-1:0]    cell_val [CAPACITY];
  logic [ResW-1:0]                res_in, res_out;

  assign op         = pirl_pkg::op_e'(operation_i);
  assign pos_lt_len = (position_i < len_q);
  assign pos_le_len = (position_i <= len_q);
  assign full       = (len_q == CapCnt);
  // Only taken when position is below the length, so the low bits address a valid cell.
  assign rd_val     = cell_val[position_i[IdxW-1:0]];

  always_comb begin
    status    = pirl_pkg::ST_OK;
    value_res = '0;
    cmd       = '0;
    len_d     = len_q;
    unique case (op)
      pirl_pkg::OP_READ: begin
        if (pos_lt_len) begin
          value_res = rd_val;
        end else begin
          status = pirl_pkg::ST_RANGE;
        end
      end
      pirl_pkg::OP_INSERT: begin
        if (!pos_le_len) begin
          status = pirl_pkg::ST_RANGE;
        end else if (full) begin
          status = pirl_pkg::ST_FULL;
        end else begin
          cmd.ins = in_fire;
          len_d   = len_q + CntW'(1);
        end
      end
      pirl_pkg::OP_REMOVE: begin
        if (pos_lt_len) begin
          value_res = rd_val;
          cmd.rem   = in_fire;
          len_d     = len_q - CntW'(1);
        end else begin
          status = pirl_pkg::ST_RANGE;
        end
      end
      default: begin
        // Unused operation code: no state change, plain ok result.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (in_fire) begin
      len_q <= len_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [pirl_pkg::ValueW-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = cell_val[i];
    end else begin : g_mid_hi
      assign upper = cell_val[i+1];
    end
    pirl_cell #(
      .Idx  (i),
      .PosW (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (position_i),
      .value_i (value_in_i),
      .lower_i (lower),
      .upper_i (upper),
      .value_o (cell_val[i])
    );
  end

  assign res_in = {value_res, len_d, status};

  pirl_out_buf #(
    .DataW (ResW)
  ) u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_i      (res_in),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .data_o      (res_out),
    .out_stall_i (out_stall_i)
  );

  assign in_fire     = in_valid_i && !in_stall_o;
  assign value_out_o = res_out[ResW-1 -: pirl_pkg::ValueW];
  assign count_o     = res_out[pirl_pkg::StatusW +: CntW];
  assign status_o    = res_out[pirl_pkg::StatusW-1:0];

  // The length never exceeds the number of cells.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CapCnt)
    else $error("list length exceeds capacity");

  // A successful insert grows the length by one.
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd.ins) |=> (len_q == $past(len_q) + CntW'(1)))
    else $error("insert did not grow the length");

  // A successful remove shrinks the length by one.
  a_rem_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd.rem) |=> (len_q == $past(len_q) - CntW'(1)))
    else $error("remove did not shrink the length");

  // An error result leaves the length untouched.
  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && status != pirl_pkg::ST_OK) |=> $stable(len_q))
    else $error("error result changed the length");

  // Cells only shift on an accepted transfer.
  a_cmd_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.ins || cmd.rem) |-> (in_fire && !(cmd.ins && cmd.rem)))
    else $error("cell command without a transfer");

endmodule
